// File: rtl/rgs_pkg.sv
// Package: shared types, constants and fixed-point helpers for the grid sweep.
`timescale 1ns / 1ps
package rgs_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 4096;
    localparam int FRAC_BITS = 16;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 12;
    localparam int ADDR_W    = 5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ACCEL_BOUND = 3'd0;
    localparam logic [2:0] REG_TIME_STEP   = 3'd1;
    localparam logic [2:0] REG_INV_POS     = 3'd2;
    localparam logic [2:0] REG_INV_VEL     = 3'd3;
    localparam logic [2:0] REG_VEL_SPACING = 3'd4;
    localparam logic [2:0] REG_VEL_MIN     = 3'd5;
    localparam logic [2:0] REG_COLS_USED   = 3'd6;
    localparam logic [2:0] REG_ROWS_USED   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_CALC,
        ST_EMIT,
        ST_WRITE
    } state_t;

    typedef logic signed [31:0] val_t;
    typedef logic signed [33:0] opnd_t;
    typedef logic signed [67:0] wide_t;

    // saturate a wide signed value to the 32-bit range
    function automatic val_t sat68(input wide_t v);
        if (v > wide_t'(64'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (v < -wide_t'(64'sh8000_0000))
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // fixed-point product: floor shift by FRAC_BITS, then saturate
    function automatic val_t fsat(input wide_t p);
        wide_t sh;
        sh = p >>> FRAC_BITS;
        return sat68(sh);
    endfunction

endpackage

// File: rtl/rgs_in_if.sv
// Interfaces: input cell channel and result channel.
`timescale 1ns / 1ps
interface rgs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface rgs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_value;
    logic [7:0]         pos_index;
    logic [11:0]        vel_index;
    logic               last;

    modport source (output valid, output new_value, output pos_index,
                    output vel_index, output last, input ready);
    modport sink   (input valid, input new_value, input pos_index,
                    input vel_index, input last, output ready);
endinterface

// File: rtl/reachability_grid_sweep.sv
// Top level: line-store grid sweep with a shared sequenced multiplier.
// Each cell: line-store reads, then per result an operand load, 14 schedule steps on
// one shared 34x34 multiplier and an emit state that waits for ready, then a write-back.
// A new cell is taken only in the idle state, once the previous one is written back;
// the multiplier schedule and the single read port of each line store limit the rate.
// Reset: rst_n (async, active low) clears counters, control and config to defaults;
// line stores are not cleared.
`timescale 1ns / 1ps
module reachability_grid_sweep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rgs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    rgs_in_if.sink                     in_ch,
    rgs_out_if.source                  out_ch
);
    import rgs_pkg::*;

    // configuration registers
    logic [30:0] accel_bound_reg, time_step_reg, inv_pos_reg, inv_vel_reg, vel_spacing_reg;
    logic signed [31:0] vel_min_reg;
    logic [8:0]  cols_used_reg;
    logic [12:0] rows_used_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_bound_reg <= 31'd65536;
            time_step_reg   <= 31'd655;
            inv_pos_reg     <= 31'd65536;
            inv_vel_reg     <= 31'd65536;
            vel_spacing_reg <= 31'd65536;
            vel_min_reg     <= -32'sd8388608;
            cols_used_reg   <= 9'd256;
            rows_used_reg   <= 13'd256;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ACCEL_BOUND: accel_bound_reg <= pwdata[30:0];
                REG_TIME_STEP:   time_step_reg   <= pwdata[30:0];
                REG_INV_POS:     inv_pos_reg     <= pwdata[30:0];
                REG_INV_VEL:     inv_vel_reg     <= pwdata[30:0];
                REG_VEL_SPACING: vel_spacing_reg <= pwdata[30:0];
                REG_VEL_MIN:     vel_min_reg     <= pwdata;
                REG_COLS_USED:   cols_used_reg   <= pwdata[8:0];
                REG_ROWS_USED:   rows_used_reg   <= pwdata[12:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_ACCEL_BOUND: prdata = {1'b0, accel_bound_reg};
            REG_TIME_STEP:   prdata = {1'b0, time_step_reg};
            REG_INV_POS:     prdata = {1'b0, inv_pos_reg};
            REG_INV_VEL:     prdata = {1'b0, inv_vel_reg};
            REG_VEL_SPACING: prdata = {1'b0, vel_spacing_reg};
            REG_VEL_MIN:     prdata = vel_min_reg;
            REG_COLS_USED:   prdata = {23'd0, cols_used_reg};
            REG_ROWS_USED:   prdata = {19'd0, rows_used_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // clamped grid size
    logic [8:0]  cols_eff;
    logic [12:0] rows_eff;
    always_comb
    begin
        cols_eff = cols_used_reg;
        if (cols_used_reg < 9'd2)
            cols_eff = 9'd2;
        else if (cols_used_reg > 9'(MAX_COLS))
            cols_eff = 9'(MAX_COLS);
        rows_eff = rows_used_reg;
        if (rows_used_reg < 13'd2)
            rows_eff = 13'd2;
        else if (rows_used_reg > 13'(MAX_ROWS))
            rows_eff = 13'(MAX_ROWS);
    end

    // control state
    state_t state_reg, state_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [2:0] rcnt_reg, rcnt_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] upd_reg, upd_next;
    logic lastc_reg, lastr_reg, act1_reg, act2_reg;
    logic signed [31:0] cin_reg;

    // line-store read data
    val_t n_i_reg, n_ip1_reg, n_im1_reg, n_im2_reg, o_i_reg, o_im1_reg;

    // operands of the update in progress
    val_t u_c_reg, u_xm_reg, u_xp_reg, u_vm_reg, u_vp_reg;
    logic u_hl_reg, u_hr_reg, u_hd_reg, u_hu_reg;
    logic [ROW_W-1:0] u_row_reg;
    logic [COL_W-1:0] u_pos_reg;
    logic u_last_reg;

    // intermediates
    val_t pxm_reg, pxp_reg, pvm_reg, pvp_reg, vj_reg;
    val_t t1_reg, t2_reg, t3_reg, t4_reg, h_reg, d_reg, m_reg;
    wide_t prod_reg;

    // output register
    val_t out_value_reg;
    logic [COL_W-1:0] out_pos_reg;
    logic [ROW_W-1:0] out_vel_reg;
    logic out_last_reg;

    logic in_xfer, out_xfer;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_ch.valid     = (state_reg == ST_EMIT);
    assign out_xfer         = out_ch.valid && out_ch.ready;
    assign out_ch.new_value = out_value_reg;
    assign out_ch.pos_index = out_pos_reg;
    assign out_ch.vel_index = out_vel_reg;
    assign out_ch.last      = out_last_reg;

    // line stores
    val_t older_mem [MAX_COLS];
    val_t newer_mem [MAX_COLS];
    logic [COL_W-1:0] n_addr, o_addr;
    val_t n_rdata_reg, o_rdata_reg;
    logic mem_wr;
    assign mem_wr = (state_reg == ST_WRITE);

    always_comb
    begin
        case (rcnt_reg)
            3'd0:    n_addr = col_count_reg;
            3'd1:    n_addr = col_count_reg + COL_W'(1);
            3'd2:    n_addr = col_count_reg - COL_W'(1);
            default: n_addr = col_count_reg - COL_W'(2);
        endcase
        o_addr = (rcnt_reg == 3'd0) ? col_count_reg : col_count_reg - COL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        n_rdata_reg <= newer_mem[n_addr];
        o_rdata_reg <= older_mem[o_addr];
        if (mem_wr)
        begin
            older_mem[col_count_reg] <= n_i_reg;
            newer_mem[col_count_reg] <= cin_reg;
        end
    end

    // differences with ghost substitution
    logic signed [32:0] dxm, dxp, dvm, dvp;
    always_comb
    begin
        dxm = u_hl_reg ? 33'(u_c_reg) - 33'(u_xm_reg) : 33'(u_xp_reg) - 33'(u_c_reg);
        dxp = u_hr_reg ? 33'(u_xp_reg) - 33'(u_c_reg) : 33'(u_c_reg) - 33'(u_xm_reg);
        dvm = u_hd_reg ? 33'(u_c_reg) - 33'(u_vm_reg) : 33'(u_vp_reg) - 33'(u_c_reg);
        dvp = u_hu_reg ? 33'(u_vp_reg) - 33'(u_c_reg) : 33'(u_c_reg) - 33'(u_vm_reg);
    end

    // halves and magnitudes
    logic signed [32:0] sum_pv, sum_px, dif_px, dif_pv;
    opnd_t half_pv_abs, half_px, half_dpx, half_dpv, vj_abs;
    always_comb
    begin
        sum_pv = 33'(pvm_reg) + 33'(pvp_reg);
        sum_px = 33'(pxm_reg) + 33'(pxp_reg);
        dif_px = 33'(pxp_reg) - 33'(pxm_reg);
        dif_pv = 33'(pvp_reg) - 33'(pvm_reg);
        half_pv_abs = 34'(sum_pv >>> 1);
        if (half_pv_abs < 0)
            half_pv_abs = -half_pv_abs;
        half_px  = 34'(sum_px >>> 1);
        half_dpx = 34'(dif_px >>> 1);
        half_dpv = 34'(dif_pv >>> 1);
        vj_abs   = 34'(vj_reg);
        if (vj_abs < 0)
            vj_abs = -vj_abs;
    end

    // shared multiplier operand select
    opnd_t mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:
            begin
                mul_a = 34'(dxm);
                mul_b = opnd_t'({3'd0, inv_pos_reg});
            end
            4'd1:
            begin
                mul_a = 34'(dxp);
                mul_b = opnd_t'({3'd0, inv_pos_reg});
            end
            4'd2:
            begin
                mul_a = 34'(dvm);
                mul_b = opnd_t'({3'd0, inv_vel_reg});
            end
            4'd3:
            begin
                mul_a = 34'(dvp);
                mul_b = opnd_t'({3'd0, inv_vel_reg});
            end
            4'd4:
            begin
                mul_a = opnd_t'({22'd0, u_row_reg});
                mul_b = opnd_t'({3'd0, vel_spacing_reg});
            end
            4'd5:
            begin
                mul_a = opnd_t'({3'd0, accel_bound_reg});
                mul_b = half_pv_abs;
            end
            4'd6:
            begin
                mul_a = half_px;
                mul_b = 34'(vj_reg);
            end
            4'd7:
            begin
                mul_a = vj_abs;
                mul_b = half_dpx;
            end
            4'd8:
            begin
                mul_a = opnd_t'({3'd0, accel_bound_reg});
                mul_b = half_dpv;
            end
            4'd12:
            begin
                mul_a = opnd_t'({3'd0, time_step_reg});
                mul_b = 34'(m_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    val_t fm;
    assign fm = fsat(prod_reg);

    // saturated H + D, clamped to non-positive at step 11
    val_t hd_sum;
    assign hd_sum = sat68(wide_t'(h_reg) + wide_t'(d_reg));

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(mul_a) * 68'(mul_b);
        if (in_xfer)
            cin_reg <= in_ch.cell_value;
        // capture each address's registered read data in the following cycle
        if (state_reg == ST_READ)
        begin
            case (rcnt_reg)
                3'd1:
                begin
                    n_i_reg <= n_rdata_reg;
                    o_i_reg <= o_rdata_reg;
                end
                3'd2:
                begin
                    n_ip1_reg <= n_rdata_reg;
                    o_im1_reg <= o_rdata_reg;
                end
                3'd3:    n_im1_reg <= n_rdata_reg;
                3'd4:    n_im2_reg <= n_rdata_reg;
                default: ;
            endcase
        end
        // set up operands of the next update
        if (state_reg == ST_LOAD)
        begin
            case (upd_reg)
                2'd0:
                begin
                    u_c_reg   <= n_i_reg;
                    u_xm_reg  <= o_im1_reg;
                    u_hl_reg  <= (col_count_reg != '0);
                    u_xp_reg  <= n_ip1_reg;
                    u_hr_reg  <= !lastc_reg;
                    u_vm_reg  <= o_i_reg;
                    u_hd_reg  <= (row_count_reg >= ROW_W'(2));
                    u_vp_reg  <= cin_reg;
                    u_hu_reg  <= 1'b1;
                    u_row_reg <= row_count_reg - ROW_W'(1);
                    u_pos_reg <= col_count_reg;
                    u_last_reg <= !act1_reg && !act2_reg;
                end
                2'd1:
                begin
                    u_c_reg   <= n_im1_reg;
                    u_xm_reg  <= n_im2_reg;
                    u_hl_reg  <= (col_count_reg >= COL_W'(2));
                    u_xp_reg  <= cin_reg;
                    u_hr_reg  <= 1'b1;
                    u_vm_reg  <= o_im1_reg;
                    u_hd_reg  <= 1'b1;
                    u_vp_reg  <= '0;
                    u_hu_reg  <= 1'b0;
                    u_row_reg <= row_count_reg;
                    u_pos_reg <= col_count_reg - COL_W'(1);
                    u_last_reg <= !act2_reg;
                end
                default:
                begin
                    u_c_reg   <= cin_reg;
                    u_xm_reg  <= n_im1_reg;
                    u_hl_reg  <= (col_count_reg != '0);
                    u_xp_reg  <= '0;
                    u_hr_reg  <= 1'b0;
                    u_vm_reg  <= n_i_reg;
                    u_hd_reg  <= 1'b1;
                    u_vp_reg  <= '0;
                    u_hu_reg  <= 1'b0;
                    u_row_reg <= row_count_reg;
                    u_pos_reg <= col_count_reg;
                    u_last_reg <= 1'b1;
                end
            endcase
        end
        // store multiplier results per schedule step
        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                4'd1:  pxm_reg <= fm;
                4'd2:  pxp_reg <= fm;
                4'd3:  pvm_reg <= fm;
                4'd4:  pvp_reg <= fm;
                4'd5:  vj_reg  <= sat68(wide_t'(vel_min_reg) + prod_reg);
                4'd6:  t2_reg  <= fm;
                4'd7:  t1_reg  <= fm;
                4'd8:  t3_reg  <= fm;
                4'd9:  t4_reg  <= fm;
                4'd10:
                begin
                    h_reg <= sat68(wide_t'(t1_reg) - wide_t'(t2_reg));
                    d_reg <= sat68(wide_t'(t3_reg) + wide_t'(t4_reg));
                end
                4'd11: m_reg <= (hd_sum < 0) ? hd_sum : '0;
                4'd13:
                begin
                    out_value_reg <= sat68(wide_t'(u_c_reg) + wide_t'(fm));
                    out_pos_reg   <= u_pos_reg;
                    out_vel_reg   <= u_row_reg;
                    out_last_reg  <= u_last_reg;
                end
                default: ;
            endcase
        end
    end

    // item flags latched at the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lastc_reg <= 1'b0;
            lastr_reg <= 1'b0;
            act1_reg  <= 1'b0;
            act2_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            lastc_reg <= (9'(col_count_reg) + 9'd1 >= cols_eff);
            lastr_reg <= (13'(row_count_reg) + 13'd1 >= rows_eff);
            act1_reg  <= (row_count_reg != '0) && (13'(row_count_reg) + 13'd1 >= rows_eff)
                         && (col_count_reg != '0);
            act2_reg  <= (row_count_reg != '0) && (13'(row_count_reg) + 13'd1 >= rows_eff)
                         && (9'(col_count_reg) + 9'd1 >= cols_eff);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            rcnt_reg      <= '0;
            step_reg      <= '0;
            upd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            rcnt_reg      <= rcnt_next;
            step_reg      <= step_next;
            upd_reg       <= upd_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        rcnt_next      = rcnt_reg;
        step_next      = step_reg;
        upd_next       = upd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_READ;
                    rcnt_next  = '0;
                end
            end
            ST_READ:
            begin
                rcnt_next = rcnt_reg + 3'd1;
                if (rcnt_reg == 3'd4)
                begin
                    if (row_count_reg != '0)
                    begin
                        state_next = ST_LOAD;
                        upd_next   = 2'd0;
                    end
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_CALC;
                step_next  = '0;
            end
            ST_CALC:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd13)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (upd_reg == 2'd0 && act1_reg)
                    begin
                        upd_next   = 2'd1;
                        state_next = ST_LOAD;
                    end
                    else if (upd_reg != 2'd2 && act2_reg)
                    begin
                        upd_next   = 2'd2;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
                if (lastc_reg)
                begin
                    col_count_next = '0;
                    row_count_next = lastr_reg ? '0 : row_count_reg + ROW_W'(1);
                end
                else
                    col_count_next = col_count_reg + COL_W'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: tb/reachability_grid_sweep_tb.sv
// Testbench for the grid sweep: directed table, random passes, cycle-free predictor.
`timescale 1ns / 1ps
module reachability_grid_sweep_tb;
    import rgs_pkg::*;

    // expected sweep result
    typedef struct {
        logic signed [31:0] new_value;
        logic [7:0]         pos_index;
        logic [11:0]        vel_index;
        logic               last;
    } sweep_res_t;

    // directed row: optional register set before the cell, optional typed result
    typedef struct {
        int                 reg_set;
        logic signed [31:0] cell_in;
        bit                 typed;
        logic signed [31:0] first_value;
    } dir_row_t;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam int     DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgs_in_if  in_ch ();
    rgs_out_if out_ch ();

    reachability_grid_sweep i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // predictor state
    longint     sweep_reg [8];
    longint     older_line [MAX_COLS];
    longint     newer_line [MAX_COLS];
    int         col_pos;
    int         row_pos;
    sweep_res_t sweep_q [$];

    int  fail_count;
    int  burst_left;
    bit  no_gaps;
    bit  hold_req;
    int  hold_cnt;
    int  rx_cycle;
    int  rx_mode;

    dir_row_t dir_table [20];

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic longint sat32(input longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sat32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint line_rd(input longint line_q [MAX_COLS], input int k);
        if (k < 0 || k >= MAX_COLS) return 0;
        return line_q[k];
    endfunction

    // one Lax-Friedrichs cell update with ghost handling
    function automatic longint lf_update(input longint c, input longint xm, input bit hl,
                                         input longint xp, input bit hr,
                                         input longint vm, input bit hd,
                                         input longint vp, input bit hu,
                                         input int row);
        longint dxm, dxp, dvm, dvp, pxm, pxp, pvm, pvp, vj, h, d, s, m;
        dxm = hl ? c - xm : xp - c;
        dxp = hr ? xp - c : c - xm;
        dvm = hd ? c - vm : vp - c;
        dvp = hu ? vp - c : c - vm;
        pxm = qmul(dxm, sweep_reg[REG_INV_POS]);
        pxp = qmul(dxp, sweep_reg[REG_INV_POS]);
        pvm = qmul(dvm, sweep_reg[REG_INV_VEL]);
        pvp = qmul(dvp, sweep_reg[REG_INV_VEL]);
        vj  = sat32(sweep_reg[REG_VEL_MIN] + longint'(row) * sweep_reg[REG_VEL_SPACING]);
        h   = sat32(qmul((pxm + pxp) >>> 1, vj)
                    - qmul(sweep_reg[REG_ACCEL_BOUND], mag((pvm + pvp) >>> 1)));
        d   = sat32(qmul(mag(vj), (pxp - pxm) >>> 1)
                    + qmul(sweep_reg[REG_ACCEL_BOUND], (pvp - pvm) >>> 1));
        s   = sat32(h + d);
        m   = (s < 0) ? s : 0;
        return sat32(c + qmul(sweep_reg[REG_TIME_STEP], m));
    endfunction

    function automatic void push_res(input longint v, input int pos, input int vel);
        sweep_res_t r;
        r.new_value = v[31:0];
        r.pos_index = pos[7:0];
        r.vel_index = vel[11:0];
        r.last      = 1'b0;
        sweep_q.push_back(r);
    endfunction

    // advance the sweep by one cell, queue what it emits; returns count
    function automatic int sweep_cell(input logic signed [31:0] cell_v, output longint first_v);
        longint cols, rows, c, v;
        int     i, j, n;
        bit     lastc, lastr;
        cols = sweep_reg[REG_COLS_USED];
        rows = sweep_reg[REG_ROWS_USED];
        if (cols < 2) cols = 2;
        if (cols > MAX_COLS) cols = MAX_COLS;
        if (rows < 2) rows = 2;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        i = col_pos;
        j = row_pos;
        c = cell_v;
        lastc = (i + 1 >= cols);
        lastr = (j + 1 >= rows);
        n = 0;
        first_v = 0;
        if (j >= 1)
        begin
            v = lf_update(line_rd(newer_line, i), line_rd(older_line, i - 1), i > 0,
                          line_rd(newer_line, i + 1), !lastc,
                          line_rd(older_line, i), j >= 2, c, 1'b1, j - 1);
            first_v = v;
            push_res(v, i, j - 1);
            n++;
            if (lastr)
            begin
                if (i >= 1)
                begin
                    v = lf_update(line_rd(newer_line, i - 1), line_rd(newer_line, i - 2),
                                  i >= 2, c, 1'b1, line_rd(older_line, i - 1), 1'b1,
                                  0, 1'b0, j);
                    push_res(v, i - 1, j);
                    n++;
                end
                if (lastc)
                begin
                    v = lf_update(c, line_rd(newer_line, i - 1), i > 0, 0, 1'b0,
                                  line_rd(newer_line, i), 1'b1, 0, 1'b0, j);
                    push_res(v, i, j);
                    n++;
                end
            end
        end
        older_line[i] = newer_line[i];
        newer_line[i] = c;
        if (lastc)
        begin
            col_pos = 0;
            row_pos = lastr ? 0 : j + 1;
        end
        else
            col_pos = i + 1;
        if (n > 0) sweep_q[sweep_q.size() - 1].last = 1'b1;
        return n;
    endfunction

    // APB write: setup then access phase
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VEL_MIN:   mask = 32'hFFFF_FFFF;
            REG_COLS_USED: mask = 32'h0000_01FF;
            REG_ROWS_USED: mask = 32'h0000_1FFF;
            default:       mask = 32'h7FFF_FFFF;
        endcase
        if (idx == REG_VEL_MIN)
            sweep_reg[idx] = longint'($signed(val));
        else
            sweep_reg[idx] = longint'(val & mask);
    endtask

    task automatic write_all(input logic [31:0] accel, input logic [31:0] dt,
                             input logic [31:0] ipx, input logic [31:0] ipv,
                             input logic [31:0] vsp, input logic [31:0] vmin,
                             input logic [31:0] cols, input logic [31:0] rows);
        reg_write(REG_ACCEL_BOUND, accel);
        reg_write(REG_TIME_STEP, dt);
        reg_write(REG_INV_POS, ipx);
        reg_write(REG_INV_VEL, ipv);
        reg_write(REG_VEL_SPACING, vsp);
        reg_write(REG_VEL_MIN, vmin);
        reg_write(REG_COLS_USED, cols);
        reg_write(REG_ROWS_USED, rows);
    endtask

    // offer one cell, with bursty gaps; predict on transfer
    task automatic send_cell(input logic signed [31:0] v, output longint first_v,
                             output int n);
        if (burst_left == 0 && !no_gaps)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.cell_value <= v;
        do @(posedge clk); while (!in_ch.ready);
        n = sweep_cell(v, first_v);
    endtask

    // stop offering and wait until the block is quiet
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (sweep_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_reg31;
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(1, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_cell(input logic [31:0] base);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // result checker with its own stall pattern and long hold-off
    always @(posedge clk)
    begin
        sweep_res_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (sweep_q.size() == 0)
            begin
                $error("unexpected result at pos %0d vel %0d", out_ch.pos_index,
                       out_ch.vel_index);
                fail_count++;
            end
            else
            begin
                e = sweep_q.pop_front();
                if (out_ch.new_value !== e.new_value)
                begin
                    $error("new_value expected %0d actual %0d", e.new_value,
                           out_ch.new_value);
                    fail_count++;
                end
                if (out_ch.pos_index !== e.pos_index)
                begin
                    $error("pos_index expected %0d actual %0d", e.pos_index,
                           out_ch.pos_index);
                    fail_count++;
                end
                if (out_ch.vel_index !== e.vel_index)
                begin
                    $error("vel_index expected %0d actual %0d", e.vel_index,
                           out_ch.vel_index);
                    fail_count++;
                end
                if (out_ch.last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, out_ch.last);
                    fail_count++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end
        else
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= rx_cycle[0];
                2: out_ch.ready <= ($urandom_range(0, 9) < 7);
                default: out_ch.ready <= ($urandom_range(0, 9) < 2);
            endcase
    end

    // main sequence
    initial
    begin
        longint fv;
        int     n, k, cols, rows, passes, rand_items;
        logic [31:0] base;

        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.cell_value = '0; out_ch.ready = 1'b0;
        rst_n = 1'b0;
        fail_count = 0; burst_left = 0; no_gaps = 1'b0;
        hold_req = 1'b0; hold_cnt = 0; rx_cycle = 0; rx_mode = 0;
        col_pos = 0; row_pos = 0;
        foreach (older_line[k]) older_line[k] = 0;
        foreach (newer_line[k]) newer_line[k] = 0;
        sweep_reg[REG_ACCEL_BOUND] = 65536;
        sweep_reg[REG_TIME_STEP]   = 655;
        sweep_reg[REG_INV_POS]     = 65536;
        sweep_reg[REG_INV_VEL]     = 65536;
        sweep_reg[REG_VEL_SPACING] = 65536;
        sweep_reg[REG_VEL_MIN]     = -8388608;
        sweep_reg[REG_COLS_USED]   = 256;
        sweep_reg[REG_ROWS_USED]   = 256;

        // directed: zero step keeps values; extremes; minimal gains; typical
        dir_table = '{
            '{1, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{0, 32'h8000_0000, 1'b0, 32'h0},
            '{0, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF},
            '{0, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
            '{2, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{0, 32'h8000_0000, 1'b0, 32'h0},
            '{0, 32'h0000_0000, 1'b0, 32'h0},
            '{0, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{0, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{0, 32'h8000_0000, 1'b0, 32'h0},
            '{3, 32'h0000_3039, 1'b0, 32'h0},
            '{0, 32'hFFFF_FFFB, 1'b0, 32'h0},
            '{0, 32'h8000_0000, 1'b0, 32'h0},
            '{0, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{4, 32'h0001_0000, 1'b0, 32'h0},
            '{0, 32'h0000_0000, 1'b0, 32'h0},
            '{0, 32'hFFFF_0000, 1'b0, 32'h0},
            '{0, 32'h0002_0000, 1'b0, 32'h0},
            '{0, 32'h4000_0000, 1'b0, 32'h0},
            '{0, 32'hC000_0000, 1'b0, 32'h0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[k])
        begin
            if (dir_table[k].reg_set != 0)
            begin
                drain();
                case (dir_table[k].reg_set)
                    1: write_all(65536, 0, 65536, 65536, 65536, 32'hFF80_0000, 2, 2);
                    2: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 2, 3);
                    3: write_all(0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 1);
                    default: write_all(65536, 65536, 65536, 65536, 65536,
                                       32'hFFFE_0000, 3, 2);
                endcase
            end
            send_cell(dir_table[k].cell_in, fv, n);
            if (dir_table[k].typed && fv[31:0] !== dir_table[k].first_value)
            begin
                $error("new_value expected %0d actual %0d", dir_table[k].first_value,
                       fv[31:0]);
                fail_count++;
            end
        end
        drain();

        // full-width first row (columns clamped down), no gaps
        write_all(65536, 655, 65536, 65536, 65536, 32'hFF80_0000, 511, 256);
        no_gaps = 1'b1;
        base = $urandom;
        for (k = 0; k < 256; k++) send_cell(rand_cell(base), fv, n);
        drain();
        // grid shrunk mid-pass: current row becomes the last; long receiver hold-off
        reg_write(REG_COLS_USED, 8);
        reg_write(REG_ROWS_USED, 0);
        hold_req = 1'b1;
        for (k = 0; k < 8; k++) send_cell(rand_cell(base), fv, n);
        no_gaps = 1'b0;
        drain();

        // very tall grid (rows clamped), then cut short mid-pass
        write_all(65536, 65536, 65536, 65536, 65536, 0, 2, 8191);
        for (k = 0; k < 8; k++) send_cell(rand_cell(base), fv, n);
        drain();
        reg_write(REG_ROWS_USED, 2);
        for (k = 0; k < 2; k++) send_cell(rand_cell(base), fv, n);
        drain();

        // random passes with random register settings
        rand_items = 0;
        while (rand_items < 56)
        begin
            cols = $urandom_range(2, 6);
            rows = $urandom_range(2, 4);
            write_all(rand_reg31(), rand_reg31(), rand_reg31(), rand_reg31(), rand_reg31(),
                      ($urandom_range(0, 3) == 0) ? $urandom
                                                  : 32'hFFF0_0000 + $urandom_range(0, 32'h20_0000),
                      cols, rows);
            passes = $urandom_range(1, 2);
            base = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
            for (k = 0; k < passes * cols * rows; k++)
            begin
                send_cell(rand_cell(base), fv, n);
                rand_items++;
            end
            drain();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
